// File: rtl/core/i2csrm_pkg.sv
package i2csrm_pkg;

    // Sequencer phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_WBIT  = 3'd2;
    localparam logic [2:0] PH_WACK  = 3'd3;
    localparam logic [2:0] PH_RBIT  = 3'd4;
    localparam logic [2:0] PH_MACK  = 3'd5;
    localparam logic [2:0] PH_STOP  = 3'd6;

    // Command codes carried with each tick.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic       REG_DEVICE_ADDRESS = 1'b0;
    localparam logic [6:0] DEV_ADDR_RESET     = 7'd28;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic        nack;
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
    } result_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  quarter;
        logic [3:0]  bit_cnt;
        logic [2:0]  byte_cnt;
        logic [7:0]  shift;
        logic [1:0]  req_cmd;
        logic [7:0]  req_reg;
        logic [7:0]  req_data;
        logic [47:0] read_buf;
        logic        nack_seen;
    } seq_state_t;

endpackage

// File: rtl/core/i2csrm_in_stage.sv
module i2csrm_in_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2csrm_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [i2csrm_pkg::IN_USER_W-1:0]   s_tuser,
    input  logic                               take,
    output logic                               item_valid,
    output i2csrm_pkg::item_t                  item
);
    import i2csrm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register frees up in the same cycle that its word moves on.
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.command    <= s_tuser[1:0];
            item_reg.reg_addr   <= s_tdata[7:0];
            item_reg.write_data <= s_tdata[15:8];
            item_reg.sda_in     <= s_tdata[16];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/i2csrm_step.sv
module i2csrm_step #(
    parameter int READ_BYTES = 6
) (
    input  i2csrm_pkg::seq_state_t cur_state,
    input  i2csrm_pkg::item_t      item,
    input  logic [6:0]             device_address,
    output i2csrm_pkg::seq_state_t next_state,
    output i2csrm_pkg::result_t    result
);
    import i2csrm_pkg::*;

    localparam logic [3:0] NUM_BYTES = 4'(READ_BYTES);

    function automatic logic [7:0] tx_byte(input logic [2:0] idx, input logic [1:0] cmd,
                                           input logic [7:0] reg_b, input logic [7:0] dat_b,
                                           input logic [6:0] dev);
        logic [7:0] adr;
        adr = {dev, 1'b0};
        if (idx == 3'd0) begin
            tx_byte = adr;
        end else if (idx == 3'd1) begin
            tx_byte = reg_b;
        end else if (cmd == CMD_WRITE) begin
            tx_byte = dat_b;
        end else begin
            tx_byte = {dev, 1'b1};
        end
    endfunction

    always_comb begin
        seq_state_t st;
        logic [1:0] q;
        logic       idle_out;
        logic [3:0] byte_inc;
        logic [5:0] slot;

        st       = cur_state;
        result   = '0;
        idle_out = 1'b0;
        byte_inc = 4'd0;
        slot     = 6'd0;

        if (st.phase == PH_IDLE) begin
            if (item.command == CMD_WRITE || item.command == CMD_READ) begin
                st.req_cmd   = item.command;
                st.req_reg   = item.reg_addr;
                st.req_data  = item.write_data;
                st.nack_seen = 1'b0;
                st.byte_cnt  = 3'd0;
                st.bit_cnt   = 4'd0;
                st.quarter   = 2'd0;
                if (item.command == CMD_READ) begin
                    st.read_buf = '0;
                end
                st.phase = PH_START;
            end else begin
                idle_out = 1'b1;
            end
        end

        q = st.quarter;
        result.scl      = (q == 2'd1) || (q == 2'd2);
        result.busy_res = 1'b1;

        if (!idle_out) begin
            unique case (st.phase)
                PH_START: begin
                    result.sda_out   = (q < 2'd2);
                    result.sda_drive = 1'b1;
                    if (q == 2'd3) begin
                        st.shift   = tx_byte(st.byte_cnt, st.req_cmd, st.req_reg,
                                             st.req_data, device_address);
                        st.bit_cnt = 4'd0;
                        st.phase   = PH_WBIT;
                    end
                end
                PH_WBIT: begin
                    result.sda_out   = st.shift[7];
                    result.sda_drive = 1'b1;
                    if (q == 2'd3) begin
                        st.shift   = {st.shift[6:0], 1'b0};
                        st.bit_cnt = st.bit_cnt + 4'd1;
                        if (st.bit_cnt >= 4'd8) begin
                            st.phase = PH_WACK;
                        end
                    end
                end
                PH_WACK: begin
                    if (q == 2'd2) begin
                        st.shift = {7'd0, item.sda_in};
                    end
                    if (q == 2'd3) begin
                        priority if (st.shift[0]) begin
                            st.nack_seen = 1'b1;
                            st.phase     = PH_STOP;
                        end else if (st.req_cmd == CMD_WRITE) begin
                            if (st.byte_cnt >= 3'd2) begin
                                st.phase = PH_STOP;
                            end else begin
                                st.byte_cnt = st.byte_cnt + 3'd1;
                                st.shift    = tx_byte(st.byte_cnt, st.req_cmd, st.req_reg,
                                                      st.req_data, device_address);
                                st.bit_cnt  = 4'd0;
                                st.phase    = PH_WBIT;
                            end
                        end else if (st.byte_cnt == 3'd0) begin
                            st.byte_cnt = 3'd1;
                            st.shift    = tx_byte(st.byte_cnt, st.req_cmd, st.req_reg,
                                                  st.req_data, device_address);
                            st.bit_cnt  = 4'd0;
                            st.phase    = PH_WBIT;
                        end else if (st.byte_cnt == 3'd1) begin
                            // Repeated start before the read address.
                            st.byte_cnt = 3'd2;
                            st.phase    = PH_START;
                        end else begin
                            st.byte_cnt = 3'd0;
                            st.bit_cnt  = 4'd0;
                            st.shift    = 8'd0;
                            st.phase    = PH_RBIT;
                        end
                    end
                end
                PH_RBIT: begin
                    if (q == 2'd2) begin
                        st.shift = {st.shift[6:0], item.sda_in};
                    end
                    if (q == 2'd3) begin
                        st.bit_cnt = st.bit_cnt + 4'd1;
                        if (st.bit_cnt >= 4'd8) begin
                            if (st.byte_cnt < 3'd6) begin
                                slot = 6'd40 - {st.byte_cnt, 3'b000};
                                st.read_buf[slot +: 8] = st.shift;
                            end
                            st.phase = PH_MACK;
                        end
                    end
                end
                PH_MACK: begin
                    byte_inc = {1'b0, st.byte_cnt} + 4'd1;
                    // The final byte gets a NACK, all others an ACK.
                    result.sda_out   = (byte_inc >= NUM_BYTES);
                    result.sda_drive = 1'b1;
                    if (q == 2'd3) begin
                        st.byte_cnt = byte_inc[2:0];
                        if ({1'b0, st.byte_cnt} >= NUM_BYTES) begin
                            st.phase = PH_STOP;
                        end else begin
                            st.bit_cnt = 4'd0;
                            st.shift   = 8'd0;
                            st.phase   = PH_RBIT;
                        end
                    end
                end
                PH_STOP: begin
                    result.scl       = (q != 2'd0);
                    result.sda_out   = (q >= 2'd2);
                    result.sda_drive = 1'b1;
                    if (q == 2'd3) begin
                        result.done_res = 1'b1;
                        result.nack     = st.nack_seen;
                        if (!st.nack_seen && st.req_cmd == CMD_READ) begin
                            result.accel_x = st.read_buf[47:32];
                            result.accel_y = st.read_buf[31:16];
                            result.accel_z = st.read_buf[15:0];
                        end
                        st.phase = PH_IDLE;
                    end
                end
                default: begin
                    st.phase = PH_IDLE;
                end
            endcase
            st.quarter = (st.phase == PH_IDLE) ? 2'd0 : q + 2'd1;
        end else begin
            result           = '0;
            result.scl       = 1'b1;
            result.sda_out   = 1'b1;
            result.sda_drive = 1'b1;
        end

        next_state = st;
    end

endmodule

// File: rtl/core/i2c_sensor_register_master_top.sv
// Channel | Ports                         | Word contents (lowest bit first)
// input   | s_tvalid s_tready s_tdata s_tuser | tuser: command; tdata: reg_addr,
//         |                               |   write_data, sda_in
// result  | m_tvalid m_tready m_tdata     | scl, sda_out, sda_drive, busy_res,
//         |                               |   done_res, nack, accel_x, accel_y, accel_z
// config  | psel penable pwrite paddr pwdata prdata pready | device_address at 0
//
// One input word, one quarter-bit tick, is taken every clock unless the result channel
// stalls; each gives one result. A taken word passes from the input register through the
// sequencer step logic into the result register, from which it leaves on the result channel.
// Reset (aresetn low, synchronous) returns the sequencer to idle with all counters cleared
// and device_address at 28. A stalled result holds in the result register while the
// input register keeps one more word; s_tready drops only when both are full.
module i2c_sensor_register_master_top #(
    parameter int READ_BYTES = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] reg_addr, [15:8] write_data, [16] sda_in, [23:17] zero
    input  logic [i2csrm_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] command
    input  logic [i2csrm_pkg::IN_USER_W-1:0]    s_tuser,
    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res, [5] nack,
    // [21:6] accel_x, [37:22] accel_y, [53:38] accel_z, [55:54] zero
    output logic [i2csrm_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import i2csrm_pkg::*;

    logic       item_valid;
    item_t      item;
    logic       advance;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    step_result;
    logic       out_valid_reg;
    result_t    out_reg;
    logic [6:0] dev_addr_reg;

    // The input word moves into the result register whenever that register is
    // empty or being emptied this cycle.
    assign advance = item_valid && (!out_valid_reg || m_tready);

    i2csrm_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2csrm_step #(
        .READ_BYTES (READ_BYTES)
    ) u_step (
        .cur_state      (state_reg),
        .item           (item),
        .device_address (dev_addr_reg),
        .next_state     (state_next),
        .result         (step_result)
    );

    // Sequencer state advances once per consumed tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.accel_z, out_reg.accel_y, out_reg.accel_x,
                       out_reg.nack, out_reg.done_res, out_reg.busy_res,
                       out_reg.sda_drive, out_reg.sda_out, out_reg.scl};

    // Register file: one register, decoded on the word address bit.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEV_ADDR_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_DEVICE_ADDRESS) begin
            dev_addr_reg <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEVICE_ADDRESS) ? {25'd0, dev_addr_reg} : 32'd0;

    // An active transaction always belongs to a write or a read request.
    a_req_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase != PH_IDLE |-> (state_reg.req_cmd == CMD_WRITE
                                        || state_reg.req_cmd == CMD_READ))
        else $error("active phase without a latched request");

    // The quarter counter sits at zero whenever the bus is idle.
    a_idle_quarter: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_IDLE |-> state_reg.quarter == 2'd0)
        else $error("quarter counter running while idle");

    // A done pulse returns the sequencer to idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_result.done_res |=> state_reg.phase == PH_IDLE)
        else $error("sequencer not idle after done");

    // A waiting input word is not dropped.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !advance |=> item_valid)
        else $error("input word lost while stalled");

    // Byte counter never runs past the read length.
    a_byte_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_RBIT |-> {1'b0, state_reg.byte_cnt} < 4'(READ_BYTES))
        else $error("read byte counter out of range");

endmodule
